FILE: design/paged_bump_allocator_core_macros.svh
// Assertion macros shared by the paged bump allocator checkers.
`ifndef PAGED_BUMP_ALLOCATOR_CORE_MACROS_SVH
`define PAGED_BUMP_ALLOCATOR_CORE_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define PBA_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion, active in reset too.
`define PBA_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/pba_pkg.sv
// Types and constants of the paged bump allocator.
`default_nettype none
package pba_pkg;

    localparam int PAGE_BYTES = 65536;
    localparam int MAX_PAGES  = 16;

    localparam int REQ_W    = 20;
    localparam int ROUND_W  = REQ_W + 1;
    localparam int UNIT_SH  = 8;
    localparam int PAGE_W   = $clog2(MAX_PAGES);
    localparam int CNT_W    = $clog2(MAX_PAGES + 1);
    localparam int USED_W   = $clog2(PAGE_BYTES + 1);
    localparam int UNITS_W  = 9;
    localparam int OFS_W    = 16;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_PAGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

FILE: design/paged_bump_allocator_core.sv
// Paged bump allocator: one request at a time, result through an output register.
// Each request word carries a byte count that is rounded up to a multiple of 256
// bytes. A single adder/comparator walks the page fill counters from the newest
// open page down to page 0, one counter per cycle, and the first page with room
// serves the request; if none has room a new page is opened while pages remain.
// A request passes through these steps from acceptance until the block is ready
// again: taking the word, one scan step per open page checked plus one decision
// step when all of them are full, and handing the result to the output register.
// A request that is too large is rejected in its first scan step. While the
// previous result still waits in the output register, the last step holds. The
// scan loop over the per-page counters sets the rate. Counters and the open page
// count clear on reset.
`default_nettype none
module paged_bump_allocator_core
    import pba_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [19:0] request_bytes
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [3:0] page_index, [12:4] size_units,
                                                // [28:13] byte_offset
    output logic [STAT_W-1:0]        m_tuser    // [1:0] status
);

    state_t              state_reg, state_next;
    logic [ROUND_W-1:0]  rounded_reg, rounded_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pages_open_reg, pages_open_next;
    logic [USED_W-1:0]   used_reg [MAX_PAGES];

    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [UNITS_W-1:0]  res_units_reg, res_units_next;
    logic [OFS_W-1:0]    res_offset_reg, res_offset_next;
    status_t             res_status_reg, res_status_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                used_we;
    logic [PAGE_W-1:0]   used_waddr;
    logic [USED_W-1:0]   used_wdata;

    logic [ROUND_W-1:0]  req_rounded;
    logic [CNT_W-1:0]    idx_dec;
    logic [PAGE_W-1:0]   page_sel;
    logic [USED_W:0]     sum;
    logic                fits;
    logic                too_large;
    logic [UNITS_W-1:0]  units;

    assign req_rounded = ({1'b0, s_tdata[REQ_W-1:0]} + ROUND_W'(255))
                         & ~ROUND_W'(255);
    assign idx_dec     = idx_reg - CNT_W'(1);
    assign page_sel    = idx_dec[PAGE_W-1:0];
    // shared adder/comparator: fill of the page under test plus the request
    assign sum         = {1'b0, used_reg[page_sel]} + rounded_reg[USED_W:0];
    assign fits        = (sum <= (USED_W+1)'(PAGE_BYTES));
    assign too_large   = (rounded_reg > ROUND_W'(PAGE_BYTES));
    assign units       = rounded_reg[UNIT_SH +: UNITS_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        rounded_next    = rounded_reg;
        idx_next        = idx_reg;
        pages_open_next = pages_open_reg;
        res_page_next   = res_page_reg;
        res_units_next  = res_units_reg;
        res_offset_next = res_offset_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        used_we         = 1'b0;
        used_waddr      = page_sel;
        used_wdata      = sum[USED_W-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    rounded_next = req_rounded;
                    idx_next     = pages_open_reg;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (too_large) begin
                    res_page_next   = '0;
                    res_units_next  = '0;
                    res_offset_next = '0;
                    res_status_next = ST_TOO_LARGE;
                    state_next      = S_EMIT;
                end else if (idx_reg == '0) begin
                    // every open page is full: open a new one if any remain
                    if (pages_open_reg < CNT_W'(MAX_PAGES)) begin
                        used_we         = 1'b1;
                        used_waddr      = pages_open_reg[PAGE_W-1:0];
                        used_wdata      = rounded_reg[USED_W-1:0];
                        pages_open_next = pages_open_reg + CNT_W'(1);
                        res_page_next   = pages_open_reg[PAGE_W-1:0];
                        res_units_next  = units;
                        res_offset_next = '0;
                        res_status_next = ST_OK;
                    end else begin
                        res_page_next   = '0;
                        res_units_next  = '0;
                        res_offset_next = '0;
                        res_status_next = ST_NO_PAGE;
                    end
                    state_next = S_EMIT;
                end else if (fits) begin
                    used_we         = 1'b1;
                    res_page_next   = page_sel;
                    res_units_next  = units;
                    res_offset_next = used_reg[page_sel][OFS_W-1:0];
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                end else begin
                    idx_next = idx_dec;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_DATA_W-PAGE_W-UNITS_W-OFS_W)'(0),
                                     res_offset_reg, res_units_reg, res_page_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pages_open_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < MAX_PAGES; i++) begin
                used_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            pages_open_reg <= pages_open_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (used_we) begin
                used_reg[used_waddr] <= used_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rounded_reg    <= rounded_next;
        idx_reg        <= idx_next;
        res_page_reg   <= res_page_next;
        res_units_reg  <= res_units_next;
        res_offset_reg <= res_offset_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule
`default_nettype wire

FILE: design/pba_checker.sv
// Port-level checker for the paged bump allocator, bound to the top level.
`default_nettype none
`include "paged_bump_allocator_core_macros.svh"
module pba_checker
    import pba_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [STAT_W-1:0]   m_tuser
);

    // no result word may survive reset
    `PBA_ASSERT(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // one request at a time: busy right after taking a word
    `PBA_ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready right after accept")

    // a failed request carries no page, size or offset
    `PBA_ASSERT_RST(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser == ST_TOO_LARGE || m_tuser == ST_NO_PAGE) |-> m_tdata == '0, "failed request with nonzero data")

    // a served request never exceeds one page of units
    `PBA_ASSERT_RST(a_units_range, aclk, aresetn, m_tvalid && m_tuser == ST_OK |-> m_tdata[12:4] <= 9'd256, "size_units beyond a page")

    // stalled result holds
    `PBA_ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind paged_bump_allocator_core pba_checker u_pba_checker (.*);
`default_nettype wire
